[rtl/core/infix_to_postfix_converter_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("infix_to_postfix_converter: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("infix_to_postfix_converter: assertion failed");

`endif

[rtl/core/itp_pkg.sv]
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Stack sizing, operator codes and character helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);

  localparam logic [2:0] CODE_ADD    = 3'd0;
  localparam logic [2:0] CODE_SUB    = 3'd1;
  localparam logic [2:0] CODE_MUL    = 3'd2;
  localparam logic [2:0] CODE_DIV    = 3'd3;
  localparam logic [2:0] CODE_LPAREN = 3'd4;

  localparam logic [7:0] CHAR_ADD    = 8'h2B;
  localparam logic [7:0] CHAR_SUB    = 8'h2D;
  localparam logic [7:0] CHAR_MUL    = 8'h2A;
  localparam logic [7:0] CHAR_DIV    = 8'h2F;
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;

  function automatic logic is_operand(input logic [7:0] ch);
    is_operand = (ch >= 8'h30 && ch <= 8'h39) ||
                 (ch >= 8'h41 && ch <= 8'h5A) ||
                 (ch >= 8'h61 && ch <= 8'h7A);
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    case (code)
      CODE_ADD: code_char = CHAR_ADD;
      CODE_SUB: code_char = CHAR_SUB;
      CODE_MUL: code_char = CHAR_MUL;
      CODE_DIV: code_char = CHAR_DIV;
      default:  code_char = CHAR_LPAREN;
    endcase
  endfunction

endpackage

`default_nettype wire

[rtl/core/infix_to_postfix_converter.sv]
// ----------------------------------------------------------------------------
// Infix to postfix converter (shunting-yard) with an operator stack sized by itp_pkg.
// Operand, '(' and ignored requests are handled in ST_IDLE; an operand token is valid the next cycle.
// Operator, ')' and end requests go to ST_POP, which pops entries while the output is free, until ST_IDLE.
// Synchronous active-low reset empties the stack and clears the overflow flag and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_marker,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_token_char,
  output logic            out_last_of_run,
  output logic            out_stack_overflow
);

  typedef enum logic {ST_IDLE, ST_POP} state_t;
  typedef enum logic [1:0] {MODE_OP, MODE_RP, MODE_END} mode_t;

  state_t                     state_r, state_nxt;
  mode_t                      mode_r, mode_nxt;
  logic [2:0]                 code_r, code_nxt;
  logic [itp_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       hold_valid_r, hold_valid_nxt;
  logic [7:0]                 hold_char_r, hold_char_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_char_r, out_char_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       out_ovf_r, out_ovf_nxt;

  logic [2:0]                 stack_r [itp_pkg::STACK_DEPTH];
  logic [2:0]                 top_r;
  logic                       stack_we;
  logic [itp_pkg::IDX_W-1:0]  stack_wa;
  logic [2:0]                 stack_wd;
  logic [itp_pkg::IDX_W-1:0]  rd_idx;

  logic                       out_free;
  logic                       in_accept;
  logic                       empty;
  logic [itp_pkg::CNT_W-1:0]  count_dec;
  logic                       push_en;
  logic [2:0]                 push_code;
  logic                       emit;
  logic                       finish;
  logic                       end_done;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign empty     = (count_r == '0);
  assign count_dec = count_r - 1'b1;
  assign rd_idx    = count_nxt[itp_pkg::IDX_W-1:0] - 1'b1;
  assign end_done  = state_r == ST_POP && mode_r == MODE_END && empty && out_free;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    code_nxt       = code_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    hold_valid_nxt = hold_valid_r;
    hold_char_nxt  = hold_char_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    push_en        = 1'b0;
    push_code      = itp_pkg::CODE_LPAREN;
    emit           = 1'b0;
    finish         = 1'b0;
    stack_we       = 1'b0;
    stack_wa       = count_r[itp_pkg::IDX_W-1:0];
    stack_wd       = push_code;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_end_marker) begin
            mode_nxt  = MODE_END;
            state_nxt = ST_POP;
          end else if (itp_pkg::is_operand(in_char_code)) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = in_char_code;
            out_last_nxt  = 1'b1;
            out_ovf_nxt   = ovf_r;
          end else if (in_char_code == itp_pkg::CHAR_ADD) begin
            code_nxt  = itp_pkg::CODE_ADD;
            mode_nxt  = MODE_OP;
            state_nxt = ST_POP;
          end else if (in_char_code == itp_pkg::CHAR_SUB) begin
            code_nxt  = itp_pkg::CODE_SUB;
            mode_nxt  = MODE_OP;
            state_nxt = ST_POP;
          end else if (in_char_code == itp_pkg::CHAR_MUL) begin
            code_nxt  = itp_pkg::CODE_MUL;
            mode_nxt  = MODE_OP;
            state_nxt = ST_POP;
          end else if (in_char_code == itp_pkg::CHAR_DIV) begin
            code_nxt  = itp_pkg::CODE_DIV;
            mode_nxt  = MODE_OP;
            state_nxt = ST_POP;
          end else if (in_char_code == itp_pkg::CHAR_LPAREN) begin
            push_en   = 1'b1;
            push_code = itp_pkg::CODE_LPAREN;
          end else if (in_char_code == itp_pkg::CHAR_RPAREN) begin
            mode_nxt  = MODE_RP;
            state_nxt = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (out_free) begin
          case (mode_r)
            MODE_OP: begin
              if (empty || top_r == itp_pkg::CODE_LPAREN ||
                  (!top_r[1] && code_r[1])) begin
                finish    = 1'b1;
                push_en   = 1'b1;
                push_code = code_r;
              end else begin
                emit      = 1'b1;
                count_nxt = count_dec;
              end
            end
            MODE_RP: begin
              if (empty) begin
                finish = 1'b1;
              end else begin
                count_nxt = count_dec;
                if (top_r == itp_pkg::CODE_LPAREN) begin
                  finish = 1'b1;
                end else begin
                  emit = 1'b1;
                end
              end
            end
            MODE_END: begin
              if (empty) begin
                finish  = 1'b1;
                ovf_nxt = 1'b0;
              end else begin
                count_nxt = count_dec;
                if (top_r != itp_pkg::CODE_LPAREN) begin
                  emit = 1'b1;
                end
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase

          if (emit) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = hold_char_r;
              out_last_nxt  = 1'b0;
              out_ovf_nxt   = ovf_r;
            end
            hold_valid_nxt = 1'b1;
            hold_char_nxt  = itp_pkg::code_char(top_r);
          end

          if (finish) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = hold_char_r;
              out_last_nxt  = 1'b1;
              out_ovf_nxt   = ovf_r;
            end
            hold_valid_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (push_en) begin
      if (count_r < itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH)) begin
        stack_we  = 1'b1;
        stack_wd  = push_code;
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_OP;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    code_r      <= code_nxt;
    hold_char_r <= hold_char_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  // The top entry is read into top_r; a push in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_r[stack_wa] <= stack_wd;
    end
    top_r <= stack_we ? stack_wd : stack_r[rd_idx];
  end

  assign out_valid          = out_valid_r;
  assign out_token_char     = out_char_r;
  assign out_last_of_run    = out_last_r;
  assign out_stack_overflow = out_ovf_r;

`include "infix_to_postfix_converter_assert.svh"

  `ITP_ASSERT_SAME(a_count_bound, 1'b1, count_r <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
  `ITP_ASSERT_SAME(a_idle_no_hold, state_r == ST_IDLE, !hold_valid_r)
  `ITP_ASSERT_NEXT(a_end_clears, end_done, count_r == '0 && !ovf_r && state_r == ST_IDLE)

endmodule

`default_nettype wire

[test/infix_to_postfix_converter_checker.sv]
// ----------------------------------------------------------------------------
// Infix to postfix converter checker
// Watches both channels, predicts the postfix tokens of every accepted request
// with its own operator stack, and compares each accepted token in order.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic       in_end_marker,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_token_char,
  input  logic       out_last_of_run,
  input  logic       out_stack_overflow,
  output int         failures,
  output int         pending_tokens
);

  typedef struct packed {
    logic [7:0] token_char;
    logic       last_of_run;
    logic       stack_overflow;
  } token_t;

  logic [2:0]  op_stack [itp_pkg::STACK_DEPTH];
  int unsigned depth_used;
  logic        overflow_seen;
  token_t      expected_tokens [$];
  int          error_tally = 0;

  function automatic int unsigned rank(input logic [2:0] code);
    case (code)
      itp_pkg::CODE_ADD, itp_pkg::CODE_SUB: return 1;
      itp_pkg::CODE_MUL, itp_pkg::CODE_DIV: return 2;
      default:                              return 0;
    endcase
  endfunction

  function automatic logic [7:0] op_symbol(input logic [2:0] code);
    case (code)
      itp_pkg::CODE_ADD: return itp_pkg::CHAR_ADD;
      itp_pkg::CODE_SUB: return itp_pkg::CHAR_SUB;
      itp_pkg::CODE_MUL: return itp_pkg::CHAR_MUL;
      default:           return itp_pkg::CHAR_DIV;
    endcase
  endfunction

  task automatic push_op(input logic [2:0] code);
    if (depth_used >= itp_pkg::STACK_DEPTH) begin
      overflow_seen = 1'b1;
    end else begin
      op_stack[depth_used] = code;
      depth_used++;
    end
  endtask

  task automatic predict_request(input logic [7:0] ch, input logic em);
    logic [7:0] run [$];
    logic [2:0] code;
    logic [2:0] head;
    logic       alnum;
    token_t     tok;
    alnum = (ch >= "0" && ch <= "9") || (ch >= "A" && ch <= "Z") ||
            (ch >= "a" && ch <= "z");
    if (em) begin
      while (depth_used > 0) begin
        depth_used--;
        head = op_stack[depth_used];
        if (head != itp_pkg::CODE_LPAREN) run.push_back(op_symbol(head));
      end
    end else if (alnum) begin
      run.push_back(ch);
    end else if (ch == itp_pkg::CHAR_ADD || ch == itp_pkg::CHAR_SUB ||
                 ch == itp_pkg::CHAR_MUL || ch == itp_pkg::CHAR_DIV) begin
      code = (ch == itp_pkg::CHAR_ADD) ? itp_pkg::CODE_ADD :
             (ch == itp_pkg::CHAR_SUB) ? itp_pkg::CODE_SUB :
             (ch == itp_pkg::CHAR_MUL) ? itp_pkg::CODE_MUL : itp_pkg::CODE_DIV;
      while (depth_used > 0) begin
        head = op_stack[depth_used - 1];
        if (head == itp_pkg::CODE_LPAREN || rank(head) < rank(code)) break;
        run.push_back(op_symbol(head));
        depth_used--;
      end
      push_op(code);
    end else if (ch == itp_pkg::CHAR_LPAREN) begin
      push_op(itp_pkg::CODE_LPAREN);
    end else if (ch == itp_pkg::CHAR_RPAREN) begin
      while (depth_used > 0) begin
        depth_used--;
        head = op_stack[depth_used];
        if (head == itp_pkg::CODE_LPAREN) break;
        run.push_back(op_symbol(head));
      end
    end
    foreach (run[i]) begin
      tok.token_char     = run[i];
      tok.last_of_run    = (i == run.size() - 1);
      tok.stack_overflow = overflow_seen;
      expected_tokens.push_back(tok);
    end
    if (em) begin
      depth_used    = 0;
      overflow_seen = 1'b0;
    end
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token: token_char %h", out_token_char);
      error_tally++;
    end else begin
      want = expected_tokens.pop_front();
      if (out_token_char !== want.token_char) begin
        $error("token_char: expected %h, actual %h", want.token_char, out_token_char);
        error_tally++;
      end
      if (out_last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %b, actual %b", want.last_of_run, out_last_of_run);
        error_tally++;
      end
      if (out_stack_overflow !== want.stack_overflow) begin
        $error("stack_overflow: expected %b, actual %b", want.stack_overflow,
               out_stack_overflow);
        error_tally++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      depth_used    = 0;
      overflow_seen = 1'b0;
      expected_tokens.delete();
    end else begin
      if (out_valid && !out_stall) check_token();
      if (in_valid && !in_stall) predict_request(in_char_code, in_end_marker);
    end
    pending_tokens <= expected_tokens.size();
    failures       <= error_tally;
  end

endmodule

[test/infix_to_postfix_converter_tb.sv]
// ----------------------------------------------------------------------------
// Infix to postfix converter testbench
// Drives directed and random infix expressions, broken sequences and noise
// with random gaps on both channels; a separate checker judges every token.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_tb;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_code;
  logic       in_end_marker;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_token_char;
  logic       out_last_of_run;
  logic       out_stack_overflow;
  int         mismatch_total;
  int         tokens_outstanding;

  logic [7:0] expr_chars [$];
  int         items_sent;
  logic       in_quiet;
  logic       out_quiet;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  infix_to_postfix_converter dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .in_end_marker      (in_end_marker),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_char     (out_token_char),
    .out_last_of_run    (out_last_of_run),
    .out_stack_overflow (out_stack_overflow)
  );

  infix_to_postfix_converter_checker postfix_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_char_code       (in_char_code),
    .in_end_marker      (in_end_marker),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_token_char     (out_token_char),
    .out_last_of_run    (out_last_of_run),
    .out_stack_overflow (out_stack_overflow),
    .failures           (mismatch_total),
    .pending_tokens     (tokens_outstanding)
  );

  function automatic logic [7:0] random_operand();
    case ($urandom_range(0, 2))
      0:       return 8'(8'h30 + $urandom_range(0, 9));
      1:       return 8'(8'h41 + $urandom_range(0, 25));
      default: return 8'(8'h61 + $urandom_range(0, 25));
    endcase
  endfunction

  function automatic logic [7:0] random_op();
    case ($urandom_range(0, 3))
      0:       return itp_pkg::CHAR_ADD;
      1:       return itp_pkg::CHAR_SUB;
      2:       return itp_pkg::CHAR_MUL;
      default: return itp_pkg::CHAR_DIV;
    endcase
  endfunction

  task automatic send_request(input logic [7:0] ch, input logic em);
    int gap;
    gap = in_quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid     <= 1'b0;
      in_char_code <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_code  <= ch;
    in_end_marker <= em;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic send_end();
    send_request(8'($urandom), 1'b1);
  endtask

  task automatic send_queued();
    foreach (expr_chars[i]) send_request(expr_chars[i], 1'b0);
    expr_chars.delete();
  endtask

  task automatic build_expr(input int levels);
    int terms;
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) expr_chars.push_back(random_op());
      if (levels > 0 && $urandom_range(0, 2) == 0) begin
        expr_chars.push_back(itp_pkg::CHAR_LPAREN);
        build_expr(levels - 1);
        expr_chars.push_back(itp_pkg::CHAR_RPAREN);
      end else begin
        expr_chars.push_back(random_operand());
      end
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    out_quiet = 1'b0;
    @(posedge clk);
    forever begin
      int hold;
      for (int n = 0; n < 32; n++) begin
        hold = out_quiet ? 0 : $urandom_range(0, 16);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!(out_valid && !out_stall)) @(posedge clk);
      end
      out_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int pick;
    int levels;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_char_code  <= 8'h00;
    in_end_marker <= 1'b0;
    in_quiet      = 1'b0;
    items_sent    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_text("a+b*c");
    send_end();
    send_text(")");
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_text("(z-9)/Z(");
    send_end();
    send_text("1-2)");
    send_request(8'hFF, 1'b1);

    while (items_sent < 410) begin
      in_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        build_expr($urandom_range(0, 4));
        send_queued();
        send_end();
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 12)) begin
          case ($urandom_range(0, 3))
            0:       expr_chars.push_back(itp_pkg::CHAR_LPAREN);
            1:       expr_chars.push_back(itp_pkg::CHAR_RPAREN);
            2:       expr_chars.push_back(random_op());
            default: expr_chars.push_back(random_operand());
          endcase
        end
        send_queued();
        if ($urandom_range(0, 1) == 0) send_end();
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) send_request(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        // Nested operator and parenthesis pairs fill the stack, often past its depth.
        levels = $urandom_range(5, 12);
        repeat (levels) begin
          expr_chars.push_back(random_operand());
          expr_chars.push_back(random_op());
          expr_chars.push_back(itp_pkg::CHAR_LPAREN);
        end
        expr_chars.push_back(random_operand());
        repeat ($urandom_range(0, levels)) expr_chars.push_back(itp_pkg::CHAR_RPAREN);
        send_queued();
        send_end();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
